// ===== hdl/civ_pkg.sv =====
// ----------------------------------------------------------------------------
// civ_pkg: shared definitions for the settings image validator
// Error codes, checksum constants, configuration register indexes and the
// result structure passed from the scan engine to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package civ_pkg;

  localparam int CIV_OFFSET_BITS_DEF = 16;

  // Width used for offset sums and limit compares; holds any offset plus any
  // 16-bit record length.
  localparam int SUM_W = 18;

  localparam int REGION_W  = 16;
  localparam int VERSION_W = 8;
  localparam int LENGTH_W  = 16;
  localparam int ERR_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [REGION_W-1:0]  REGION_BYTES_RST = 16'd16384;
  localparam logic [VERSION_W-1:0] EXP_VERSION_RST  = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 1'd1;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE = 16'h1D0F;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  MAGIC_BYTE  = 8'hBE;
  localparam logic [15:0] MIN_RECORD  = 16'd6;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_MAGIC = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_BIG   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_SMALL = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CRC       = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd5;

  typedef struct packed {
    logic                hit;
    logic                image_ok;
    logic [ERR_W-1:0]    error_code;
    logic                version_match;
    logic [LENGTH_W-1:0] image_length;
  } civ_result_t;

endpackage

`default_nettype wire

// ===== hdl/civ_crc_step.sv =====
// ----------------------------------------------------------------------------
// civ_crc_step: one byte of CRC-16/CCITT-FALSE
// Combinational update of the running checksum, MSB first, no reflection.
// ----------------------------------------------------------------------------
`default_nettype none

module civ_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import civ_pkg::*;

  logic [15:0] crc_work;

  always_comb begin
    crc_work = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc_work[15]) begin
        crc_work = {crc_work[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc_work = {crc_work[14:0], 1'b0};
      end
    end
    crc_out = crc_work;
  end

endmodule

`default_nettype wire

// ===== hdl/civ_scan.sv =====
// ----------------------------------------------------------------------------
// civ_scan: image structure scanner
// Holds the scan state and processes one byte per step, reporting a result
// when the scan ends at an error or after the second checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module civ_scan #(
  parameter int OFFSET_BITS = civ_pkg::CIV_OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  input  logic [civ_pkg::REGION_W-1:0]   region_bytes,
  input  logic [civ_pkg::VERSION_W-1:0]  expected_version,
  output civ_pkg::civ_result_t           res
);
  import civ_pkg::*;

  localparam int OW = OFFSET_BITS + 1;

  localparam logic [2:0] PH_DONE    = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_MAGIC   = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_CRC_LO  = 3'd6;
  localparam logic [2:0] PH_CRC_HI  = 3'd7;

  logic [2:0]    phase_r, phase_nxt, phase_eff;
  logic [OW-1:0] offset_r, offset_nxt, offset_eff;
  logic [OW-1:0] rec_start_r, rec_start_nxt, rec_start_eff;
  logic [15:0]   bytes_left_r, bytes_left_nxt, bytes_left_eff;
  logic [7:0]    len_low_r, len_low_nxt, len_low_eff;
  logic [15:0]   crc_r, crc_nxt, crc_eff, crc_upd;
  logic          ver_seen_r, ver_seen_nxt, ver_seen_eff;

  logic [SUM_W-1:0] limit_w, cap_w, region_w, offset_w, rec_end_w, next_len_w;
  logic [15:0]      rec_len, left_dec;

  civ_crc_step u_crc (
    .crc_in  (crc_eff),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  // A restart byte behaves as if the state had just been cleared.
  assign phase_eff      = first_byte ? PH_VERSION : phase_r;
  assign offset_eff     = first_byte ? '0 : offset_r;
  assign rec_start_eff  = first_byte ? '0 : rec_start_r;
  assign bytes_left_eff = first_byte ? '0 : bytes_left_r;
  assign len_low_eff    = first_byte ? '0 : len_low_r;
  assign crc_eff        = first_byte ? CRC_INIT : crc_r;
  assign ver_seen_eff   = first_byte ? 1'b0 : ver_seen_r;

  assign cap_w      = SUM_W'(1) << OFFSET_BITS;
  assign region_w   = SUM_W'(region_bytes);
  assign limit_w    = (region_w < cap_w) ? region_w : cap_w;
  assign offset_w   = SUM_W'(offset_eff);
  assign rec_len    = {data_byte, len_low_eff};
  assign rec_end_w  = SUM_W'(rec_start_eff) + SUM_W'(rec_len);
  assign next_len_w = offset_w + SUM_W'(1);
  assign left_dec   = bytes_left_eff - 16'd1;

  always_comb begin
    phase_nxt      = phase_eff;
    offset_nxt     = offset_eff;
    rec_start_nxt  = rec_start_eff;
    bytes_left_nxt = bytes_left_eff;
    len_low_nxt    = len_low_eff;
    crc_nxt        = crc_eff;
    ver_seen_nxt   = ver_seen_eff;
    res            = '0;
    res.version_match = ver_seen_eff;

    if (phase_eff != PH_DONE) begin
      if (offset_w >= limit_w) begin
        res.hit        = 1'b1;
        res.error_code = ERR_TRUNCATED;
        phase_nxt      = PH_DONE;
      end else begin
        crc_nxt    = crc_upd;
        offset_nxt = offset_eff + OW'(1);
        case (phase_eff)
          PH_VERSION: begin
            ver_seen_nxt = (data_byte == expected_version);
            phase_nxt    = PH_MAGIC;
          end
          PH_MAGIC: begin
            if (data_byte != MAGIC_BYTE) begin
              res.hit        = 1'b1;
              res.error_code = ERR_BAD_MAGIC;
              phase_nxt      = PH_DONE;
            end else begin
              phase_nxt = PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            len_low_nxt   = data_byte;
            rec_start_nxt = offset_eff;
            phase_nxt     = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (rec_len == 16'd0) begin
              phase_nxt = PH_CRC_LO;
            end else if (rec_end_w >= limit_w) begin
              res.hit        = 1'b1;
              res.error_code = ERR_TOO_BIG;
              phase_nxt      = PH_DONE;
            end else if (rec_len < MIN_RECORD) begin
              res.hit        = 1'b1;
              res.error_code = ERR_TOO_SMALL;
              phase_nxt      = PH_DONE;
            end else begin
              bytes_left_nxt = rec_len - 16'd2;
              phase_nxt      = PH_BODY;
            end
          end
          PH_BODY: begin
            bytes_left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              phase_nxt = PH_LEN_LO;
            end
          end
          PH_CRC_LO: begin
            phase_nxt = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            res.hit = 1'b1;
            if (crc_upd == CRC_RESIDUE) begin
              res.image_ok     = 1'b1;
              res.error_code   = ERR_OK;
              res.image_length = next_len_w[LENGTH_W-1:0];
            end else begin
              res.error_code = ERR_CRC;
            end
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DONE;
      offset_r     <= '0;
      rec_start_r  <= '0;
      bytes_left_r <= '0;
      len_low_r    <= '0;
      crc_r        <= CRC_INIT;
      ver_seen_r   <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      rec_start_r  <= rec_start_nxt;
      bytes_left_r <= bytes_left_nxt;
      len_low_r    <= len_low_nxt;
      crc_r        <= crc_nxt;
      ver_seen_r   <= ver_seen_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.hit) |=> (phase_r == PH_DONE))
    else $error("scan did not stop after reporting a result");

  a_restart_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && first_byte) |=> (phase_r == PH_DONE || offset_r == OW'(1)))
    else $error("restart byte did not leave the offset at one");

  a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> (res.error_code <= ERR_TRUNCATED))
    else $error("error code out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/config_image_validator_core.sv =====
// ----------------------------------------------------------------------------
// config_image_validator_core: streaming settings image validator
// An accepted byte waits in the input register until the output register is
// free or being emptied; a result it causes is then loaded into the output.
// Throughput: one byte per cycle while the output is not stalled, set by the
// combinational CRC byte step and scan state update; a stall holds the byte.
// Reset: synchronous, active low; clears both channel valid flags, the scan
// state (no scan running) and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module config_image_validator_core #(
  parameter int OFFSET_BITS = civ_pkg::CIV_OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [civ_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [civ_pkg::CFG_DATA_W-1:0]  cfg_data,

  // Image byte channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_first_byte,

  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_image_ok,
  output logic [civ_pkg::ERR_W-1:0]       out_error_code,
  output logic                            out_version_match,
  output logic [civ_pkg::LENGTH_W-1:0]    out_image_length
);
  import civ_pkg::*;

  // Configuration registers. Writes are to be made only while the block is idle;
  // the block itself does not enforce this, and the port is always ready.
  logic [REGION_W-1:0]  region_bytes_r;
  logic [VERSION_W-1:0] exp_version_r;

  // Input register: holds one accepted transaction until the scan takes it.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] data_r;
  logic       first_r;

  // Output register: holds one finished result until it is taken.
  logic                out_valid_r, out_valid_nxt;
  logic                image_ok_r;
  logic [ERR_W-1:0]    error_code_r;
  logic                version_match_r;
  logic [LENGTH_W-1:0] image_length_r;

  logic        advance;
  civ_result_t scan_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_bytes_r <= REGION_BYTES_RST;
      exp_version_r  <= EXP_VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION_BYTES:     region_bytes_r <= cfg_data;
        CFG_EXPECTED_VERSION: exp_version_r  <= cfg_data[VERSION_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held byte is processed whenever the output register is free or is
  // being emptied in the same cycle. Every byte waits for that, whether or
  // not it ends the scan, so results keep their order without extra storage.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r  <= in_data_byte;
      first_r <= in_first_byte;
    end
  end

  civ_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .data_byte        (data_r),
    .first_byte       (first_r),
    .region_bytes     (region_bytes_r),
    .expected_version (exp_version_r),
    .res              (scan_res)
  );

  // A processed byte that ends the scan loads the output register; a result
  // already there leaves when taken.
  always_comb begin
    if (advance) begin
      out_valid_nxt = scan_res.hit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_res.hit) begin
      image_ok_r      <= scan_res.image_ok;
      error_code_r    <= scan_res.error_code;
      version_match_r <= scan_res.version_match;
      image_length_r  <= scan_res.image_length;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_image_ok      = image_ok_r;
  assign out_error_code    = error_code_r;
  assign out_version_match = version_match_r;
  assign out_image_length  = image_length_r;

`ifndef ASSERT_OFF
  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (image_ok_r == (error_code_r == ERR_OK)))
    else $error("image_ok disagrees with error code");

  a_len_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_code_r != ERR_OK) |-> (image_length_r == '0))
    else $error("nonzero image length reported with an error");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the result side is ready");
`endif

endmodule

`default_nettype wire
